>>> rtl/core/ndp_pkg.sv
package ndp_pkg;

	// Option type codes found in the type byte
	localparam logic [7:0] OPT_SRC_MAC = 8'd1;
	localparam logic [7:0] OPT_TGT_MAC = 8'd2;
	localparam logic [7:0] OPT_PREFIX  = 8'd3;
	localparam logic [7:0] OPT_MTU     = 8'd5;
	localparam logic [7:0] OPT_DNS     = 8'd25;

	// Minimum option lengths in 8-byte units
	localparam logic [7:0] PREFIX_MIN_UNITS = 8'd4;
	localparam logic [7:0] DNS_MIN_UNITS    = 8'd3;

	// Width of the in-option byte position
	localparam int OFF_W = 11;

	// Field that a byte is shifted into
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_MAC,
		ACT_PLEN,
		ACT_FLAGS,
		ACT_WORD_A,
		ACT_WORD_B,
		ACT_ADDR
	} act_t;

	// What happens at the end of the option
	typedef enum logic [2:0] {
		FIN_NONE,
		FIN_SRC_MAC,
		FIN_TGT_MAC,
		FIN_PREFIX,
		FIN_MTU,
		FIN_DNS,
		FIN_STOP
	} fin_t;

	// Reported option kind
	typedef enum logic [2:0] {
		KIND_SRC_MAC    = 3'd0,
		KIND_TGT_MAC    = 3'd1,
		KIND_GLOBAL_PFX = 3'd2,
		KIND_ULA_PFX    = 3'd3,
		KIND_MTU        = 3'd4,
		KIND_DNS        = 3'd5,
		KIND_STOP       = 3'd6
	} kind_t;

	// Prefix classes, taken from the top of the address
	localparam logic [2:0] GLOBAL_TOP3 = 3'b001;
	localparam logic [6:0] ULA_TOP7    = 7'h7E;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  option_kind;
		logic [47:0] mac_addr;
		logic [7:0]  prefix_length;
		logic        flag_on_link;
		logic        flag_autonomous;
		logic [31:0] valid_lifetime;
		logic [31:0] preferred_lifetime;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [31:0] link_mtu;
	} out_item_t;

	// Command passed from the parser front to the field collector
	typedef struct packed {
		logic [7:0] data;
		act_t       act;
		fin_t       fin;
	} cmd_t;

endpackage

>>> rtl/core/ndp_front.sv
module ndp_front
	import ndp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  in_item_t byte_item,
	input  logic     q_full,
	output logic     push,
	output cmd_t     push_cmd
);

	logic [OFF_W-1:0] byte_offset_q, off_d, end_off;
	logic [7:0]       opt_type_q, type_d;
	logic [7:0]       opt_units_q, units_d;
	logic             halted_q, halt_d;
	logic             accept;
	act_t             act;
	fin_t             fin;

	// Which field a byte at this position of this option feeds
	function automatic act_t gather_act(input logic [7:0] typ, input logic [OFF_W-1:0] off);
		act_t a;
		a = ACT_NONE;
		case (typ)
			OPT_SRC_MAC, OPT_TGT_MAC: begin
				if (off >= OFF_W'(2) && off <= OFF_W'(7)) a = ACT_MAC;
			end
			OPT_PREFIX: begin
				if (off == OFF_W'(2)) a = ACT_PLEN;
				else if (off == OFF_W'(3)) a = ACT_FLAGS;
				else if (off <= OFF_W'(7)) a = ACT_WORD_A;
				else if (off <= OFF_W'(11)) a = ACT_WORD_B;
				else if (off >= OFF_W'(16) && off <= OFF_W'(31)) a = ACT_ADDR;
			end
			OPT_MTU: begin
				if (off >= OFF_W'(4) && off <= OFF_W'(7)) a = ACT_WORD_A;
			end
			OPT_DNS: begin
				if (off >= OFF_W'(4) && off <= OFF_W'(7)) a = ACT_WORD_A;
				else if (off >= OFF_W'(8) && off <= OFF_W'(23)) a = ACT_ADDR;
			end
			default: a = ACT_NONE;
		endcase
		return a;
	endfunction

	// Report to make once the option's final byte is in
	function automatic fin_t finish_kind(input logic [7:0] typ, input logic [7:0] units);
		fin_t f;
		f = FIN_NONE;
		case (typ)
			OPT_SRC_MAC: f = FIN_SRC_MAC;
			OPT_TGT_MAC: f = FIN_TGT_MAC;
			OPT_PREFIX:  f = (units >= PREFIX_MIN_UNITS) ? FIN_PREFIX : FIN_NONE;
			OPT_MTU:     f = FIN_MTU;
			OPT_DNS:     f = (units >= DNS_MIN_UNITS) ? FIN_DNS : FIN_NONE;
			default:     f = FIN_NONE;
		endcase
		return f;
	endfunction

	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;
	// Position of the final byte: units * 8 - 1
	assign end_off    = {opt_units_q, 3'b000} - OFF_W'(1);

	// Classify the byte and advance the option walk
	always_comb begin
		act    = ACT_NONE;
		fin    = FIN_NONE;
		off_d  = byte_offset_q;
		type_d = opt_type_q;
		units_d = opt_units_q;
		halt_d = halted_q;
		if (!halted_q) begin
			if (byte_offset_q == '0) begin
				type_d = byte_item.data_byte;
			end else if (byte_offset_q == OFF_W'(1)) begin
				units_d = byte_item.data_byte;
				if (byte_item.data_byte == 8'd0) begin
					fin    = FIN_STOP;
					halt_d = 1'b1;
				end
			end else begin
				act = gather_act(opt_type_q, byte_offset_q);
			end
			if (!halt_d) begin
				if (byte_offset_q >= OFF_W'(2) && byte_offset_q == end_off) begin
					fin   = finish_kind(opt_type_q, opt_units_q);
					off_d = '0;
				end else begin
					off_d = byte_offset_q + OFF_W'(1);
				end
			end
		end
		// packet end restarts the walk
		if (byte_item.last_byte) begin
			off_d  = '0;
			halt_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			opt_type_q    <= '0;
			opt_units_q   <= '0;
			halted_q      <= 1'b0;
		end else if (accept) begin
			byte_offset_q <= off_d;
			opt_type_q    <= type_d;
			opt_units_q   <= units_d;
			halted_q      <= halt_d;
		end
	end

	// Only bytes with work for the back end enter the queue
	assign push          = accept && (act != ACT_NONE || fin != FIN_NONE);
	assign push_cmd.data = byte_item.data_byte;
	assign push_cmd.act  = act;
	assign push_cmd.fin  = fin;

endmodule

>>> rtl/core/ndp_queue.sv
module ndp_queue
	import ndp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign head_cmd = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

>>> rtl/core/ndp_back.sv
module ndp_back
	import ndp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head_cmd,
	input  logic      q_empty,
	output logic      pop,
	output logic      opt_valid,
	input  logic      opt_stall,
	output out_item_t opt_item
);

	logic [47:0] mac_q, mac_d;
	logic [7:0]  pfx_len_q, pfx_len_d;
	logic [1:0]  flag_q, flag_d;
	logic [31:0] word_a_q, word_a_d;
	logic [31:0] word_b_q, word_b_d;
	logic [63:0] addr_hi_q, addr_hi_d;
	logic [63:0] addr_lo_q, addr_lo_d;
	logic        out_valid_q;
	out_item_t   out_q;
	out_item_t   res;
	logic        has_res;

	// Output register free or being emptied this cycle
	assign pop = !q_empty && (!out_valid_q || !opt_stall);

	// Shift the byte into its field
	always_comb begin
		mac_d     = mac_q;
		pfx_len_d = pfx_len_q;
		flag_d    = flag_q;
		word_a_d  = word_a_q;
		word_b_d  = word_b_q;
		addr_hi_d = addr_hi_q;
		addr_lo_d = addr_lo_q;
		case (head_cmd.act)
			ACT_MAC:    mac_d = {mac_q[39:0], head_cmd.data};
			ACT_PLEN:   pfx_len_d = head_cmd.data;
			ACT_FLAGS:  flag_d = head_cmd.data[7:6];
			ACT_WORD_A: word_a_d = {word_a_q[23:0], head_cmd.data};
			ACT_WORD_B: word_b_d = {word_b_q[23:0], head_cmd.data};
			ACT_ADDR: begin
				addr_hi_d = {addr_hi_q[55:0], addr_lo_q[63:56]};
				addr_lo_d = {addr_lo_q[55:0], head_cmd.data};
			end
			default: ;
		endcase
	end

	// Build the report from the updated fields
	always_comb begin
		res     = '0;
		has_res = 1'b0;
		case (head_cmd.fin)
			FIN_SRC_MAC, FIN_TGT_MAC: begin
				has_res          = 1'b1;
				res.option_kind  = (head_cmd.fin == FIN_SRC_MAC) ? KIND_SRC_MAC : KIND_TGT_MAC;
				res.mac_addr     = mac_d;
			end
			FIN_PREFIX: begin
				if (addr_hi_d[63:61] == GLOBAL_TOP3) begin
					has_res         = 1'b1;
					res.option_kind = KIND_GLOBAL_PFX;
				end else if (addr_hi_d[63:57] == ULA_TOP7) begin
					has_res         = 1'b1;
					res.option_kind = KIND_ULA_PFX;
				end
				if (has_res) begin
					res.prefix_length      = pfx_len_d;
					res.flag_on_link       = flag_d[1];
					res.flag_autonomous    = flag_d[0];
					res.valid_lifetime     = word_a_d;
					res.preferred_lifetime = word_b_d;
					res.address_high       = addr_hi_d;
					res.address_low        = addr_lo_d;
				end
			end
			FIN_MTU: begin
				has_res         = 1'b1;
				res.option_kind = KIND_MTU;
				res.link_mtu    = word_a_d;
			end
			FIN_DNS: begin
				has_res            = 1'b1;
				res.option_kind    = KIND_DNS;
				res.valid_lifetime = word_a_d;
				res.address_high   = addr_hi_d;
				res.address_low    = addr_lo_d;
			end
			FIN_STOP: begin
				has_res         = 1'b1;
				res.option_kind = KIND_STOP;
			end
			default: ;
		endcase
	end

	// Field collectors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_q     <= '0;
			pfx_len_q <= '0;
			flag_q    <= '0;
			word_a_q  <= '0;
			word_b_q  <= '0;
			addr_hi_q <= '0;
			addr_lo_q <= '0;
		end else if (pop) begin
			mac_q     <= mac_d;
			pfx_len_q <= pfx_len_d;
			flag_q    <= flag_d;
			word_a_q  <= word_a_d;
			word_b_q  <= word_b_d;
			addr_hi_q <= addr_hi_d;
			addr_lo_q <= addr_lo_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= has_res;
		end else if (!opt_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) out_q <= res;
	end

	assign opt_valid = out_valid_q;
	assign opt_item  = out_q;

endmodule

>>> rtl/core/ndp_option_parser.sv
// Channel   Direction  Handshake                Payload
// byte      in         byte_valid / byte_stall  byte_item (in_item_t)
// opt       out        opt_valid / opt_stall    opt_item (out_item_t)
//
// One byte is taken per cycle while the command queue is not full; with the
// queue empty, the option's final byte is written into the queue, then the back
// collects it into the output register, from which opt_valid rises.
// The front stalls only when the command queue (QUEUE_DEPTH entries) is full.
// A stalled report holds in the output register while the front keeps parsing.
// arst_n clears the option walk, the queue and the output valid.
module ndp_option_parser
	import ndp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	output logic      opt_valid,
	input  logic      opt_stall,
	output out_item_t opt_item
);

	logic q_full, q_empty, push, pop;
	cmd_t push_cmd, head_cmd;

	ndp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	ndp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	ndp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_cmd  (head_cmd),
		.q_empty   (q_empty),
		.pop       (pop),
		.opt_valid (opt_valid),
		.opt_stall (opt_stall),
		.opt_item  (opt_item)
	);

endmodule
